// ===== rtl/curvature_color_map_macros.svh =====
// Assertion macros shared by the colour map RTL.
// Needs a clock named clk and a synchronous reset named rst in scope.
`ifndef CURVATURE_COLOR_MAP_MACROS_SVH
`define CURVATURE_COLOR_MAP_MACROS_SVH

`ifndef SYNTHESIS
`define CCM_ASSERT_IMPLIES(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ccm: implication check failed");
`define CCM_ASSERT_DELAY(label, ante, n, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> ##n (cons)) \
    else $error("ccm: latency check failed");
`else
`define CCM_ASSERT_IMPLIES(label, ante, cons)
`define CCM_ASSERT_DELAY(label, ante, n, cons)
`endif

`endif

// ===== rtl/ccm_pkg.sv =====
// Shared types and constants for the curvature colour map.
// No dependencies.
package ccm_pkg;

  localparam int A_FRAC     = 24;
  localparam int ALPHA_BITS = A_FRAC + 1;
  localparam int X_BITS     = A_FRAC + 2;

  localparam logic [ALPHA_BITS-1:0] ALPHA_ONE  = ALPHA_BITS'(1) << A_FRAC;
  localparam logic [ALPHA_BITS-1:0] ALPHA_HALF = ALPHA_BITS'(1) << (A_FRAC - 1);
  localparam logic [X_BITS-1:0]     X_TWO      = X_BITS'(1) << (A_FRAC + 1);

  localparam int REG_INDEX_BITS = 2;
  localparam logic [REG_INDEX_BITS-1:0] REG_NEGATIVE_BOUND = REG_INDEX_BITS'(0);
  localparam logic [REG_INDEX_BITS-1:0] REG_POSITIVE_BOUND = REG_INDEX_BITS'(1);

  typedef struct packed {
    logic valid;
    logic negative;
  } ctl_t;

endpackage

// ===== rtl/curvature_color_map.sv =====
// Curvature colour map: signed Q16.16 scalar to RGB on a diverging hue scale.
// Depends on ccm_pkg, ccm_ratio and curvature_color_map_macros.svh.
//
// Usage:
//   Input: an item is taken at a rising edge where start is high and busy is
//   low. busy is low except in the cycle after a reset edge, so a new sample
//   may be offered every cycle; one item per cycle is the sustained rate.
//   Configuration: write_enable, write_index, write_data write one bound per
//   edge (index 0 negative_bound, 1 positive_bound, others ignored). Bounds
//   are picked up when an item is taken; write them only while idle.
//   Result: red_level, green_level and blue_level carry the colour for
//   exactly one cycle with done high; the transfer is at the edge ending that
//   cycle. Between the accepting edge and that transfer an item passes the
//   entry, magnitude and classify registers, the 24-stage restoring divider
//   that forms the ratio (one quotient bit per stage) and its output register,
//   then the sector select and scaling registers. Results leave in input order.
//   The receiver cannot stall; every result is shown once.
//   Reset clears all stage valid bits and both bounds to zero.
`include "curvature_color_map_macros.svh"

module curvature_color_map #(
  parameter int VALUE_BITS   = 32,
  parameter int CHANNEL_BITS = 8
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  output logic                               busy,
  input  logic signed [VALUE_BITS-1:0]       sample_value,
  input  logic                               write_enable,
  input  logic [ccm_pkg::REG_INDEX_BITS-1:0] write_index,
  input  logic [VALUE_BITS-1:0]              write_data,
  output logic                               done,
  output logic [CHANNEL_BITS-1:0]            red_level,
  output logic [CHANNEL_BITS-1:0]            green_level,
  output logic [CHANNEL_BITS-1:0]            blue_level
);

  localparam int PROD_BITS = ccm_pkg::X_BITS + CHANNEL_BITS;
  localparam int LATENCY   = ccm_pkg::A_FRAC + 6;
  localparam logic [PROD_BITS-1:0]    ROUND_HALF = PROD_BITS'(1) << (ccm_pkg::A_FRAC - 1);
  localparam logic [CHANNEL_BITS-1:0] FULL = {CHANNEL_BITS{1'b1}};

  logic [VALUE_BITS-1:0] negative_bound;
  logic [VALUE_BITS-1:0] positive_bound;

  always_ff @(posedge clk) begin
    if (rst) begin
      negative_bound <= '0;
      positive_bound <= '0;
    end else if (write_enable) begin
      case (write_index)
        ccm_pkg::REG_NEGATIVE_BOUND: negative_bound <= write_data;
        ccm_pkg::REG_POSITIVE_BOUND: positive_bound <= write_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    busy <= rst;
  end

  // entry
  ccm_pkg::ctl_t         ctl_e;
  logic [VALUE_BITS-1:0] num_e;
  logic [VALUE_BITS-1:0] den_e;

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_e.valid <= 1'b0;
    end else begin
      ctl_e.valid    <= start & ~busy;
      ctl_e.negative <= sample_value[VALUE_BITS-1];
    end
    num_e <= sample_value;
    den_e <= sample_value[VALUE_BITS-1] ? negative_bound : positive_bound;
  end

  ccm_pkg::ctl_t                 ctl_r;
  logic [ccm_pkg::ALPHA_BITS-1:0] alpha;

  ccm_ratio #(
    .VALUE_BITS(VALUE_BITS)
  ) u_ratio (
    .clk     (clk),
    .rst     (rst),
    .ctl_in  (ctl_e),
    .num     (num_e),
    .den     (den_e),
    .ctl_out (ctl_r),
    .alpha   (alpha)
  );

  // sector select: low_part means the varying channel rises with alpha
  ccm_pkg::ctl_t              ctl_x;
  logic [ccm_pkg::X_BITS-1:0] x_val;
  logic                       low_part;
  logic                       low_next;

  always_comb begin
    if (ctl_r.negative) begin
      low_next = alpha <= ccm_pkg::ALPHA_HALF;
    end else begin
      low_next = alpha < ccm_pkg::ALPHA_HALF;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_x.valid <= 1'b0;
    end else begin
      ctl_x <= ctl_r;
    end
    low_part <= low_next;
    x_val    <= low_next ? {alpha, 1'b0} : (ccm_pkg::X_TWO - {alpha, 1'b0});
  end

  // scale by full scale with round half up
  logic [PROD_BITS-1:0]    prod;
  logic [CHANNEL_BITS-1:0] level;

  assign prod  = {x_val, {CHANNEL_BITS{1'b0}}} - PROD_BITS'(x_val) + ROUND_HALF;
  assign level = prod[ccm_pkg::A_FRAC +: CHANNEL_BITS];

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= ctl_x.valid;
    end
    if (ctl_x.negative) begin
      red_level   <= '0;
      green_level <= low_part ? FULL : level;
      blue_level  <= low_part ? level : FULL;
    end else begin
      red_level   <= low_part ? level : FULL;
      green_level <= low_part ? FULL : level;
      blue_level  <= '0;
    end
  end

  `CCM_ASSERT_DELAY(a_latency, start && !busy, LATENCY, done)
  `CCM_ASSERT_IMPLIES(a_one_side_dark, done, red_level == '0 || blue_level == '0)
  `CCM_ASSERT_IMPLIES(a_one_full, done,
    red_level == FULL || green_level == FULL || blue_level == FULL)

endmodule

// ===== rtl/ccm_ratio.sv =====
// Pipelined ratio num / den clamped to 0..1 (0 when signs differ, 1 for den 0), unsigned Q1.24 result.
// Restoring division, one quotient bit per stage. Uses ccm_pkg.
`include "curvature_color_map_macros.svh"

module ccm_ratio #(
  parameter int VALUE_BITS = 32
) (
  input  logic                            clk,
  input  logic                            rst,
  input  ccm_pkg::ctl_t                   ctl_in,
  input  logic [VALUE_BITS-1:0]           num,
  input  logic [VALUE_BITS-1:0]           den,
  output ccm_pkg::ctl_t                   ctl_out,
  output logic [ccm_pkg::ALPHA_BITS-1:0]  alpha
);

  localparam int NSTAGE = ccm_pkg::A_FRAC;

  // magnitude stage
  ccm_pkg::ctl_t         ctl_a;
  logic [VALUE_BITS-1:0] mag_n;
  logic [VALUE_BITS-1:0] mag_u;
  logic                  den_zero;
  logic                  sign_diff;

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_a.valid <= 1'b0;
    end else begin
      ctl_a <= ctl_in;
    end
    mag_n     <= num[VALUE_BITS-1] ? (~num + VALUE_BITS'(1)) : num;
    mag_u     <= den[VALUE_BITS-1] ? (~den + VALUE_BITS'(1)) : den;
    den_zero  <= (den == '0);
    sign_diff <= num[VALUE_BITS-1] ^ den[VALUE_BITS-1];
  end

  // division pipeline; index 0 holds the classified operands
  ccm_pkg::ctl_t                 ctl_s   [0:NSTAGE];
  logic [VALUE_BITS-1:0]         rem     [0:NSTAGE];
  logic [VALUE_BITS-1:0]         divisor [0:NSTAGE];
  logic [ccm_pkg::A_FRAC-1:0]    quo     [0:NSTAGE];
  logic                          one_s   [0:NSTAGE];
  logic                          zero_s  [0:NSTAGE];

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_s[0].valid <= 1'b0;
    end else begin
      ctl_s[0] <= ctl_a;
    end
    rem[0]     <= mag_n;
    divisor[0] <= mag_u;
    quo[0]     <= '0;
    one_s[0]   <= den_zero | ((mag_n != '0) & ~sign_diff & (mag_n >= mag_u));
    zero_s[0]  <= ~den_zero & ((mag_n == '0) | sign_diff);
  end

  for (genvar k = 1; k <= NSTAGE; k++) begin : g_div
    logic [VALUE_BITS:0] shifted;
    logic [VALUE_BITS:0] diff;
    logic                ge;

    assign shifted = {rem[k-1], 1'b0};
    assign diff    = shifted - {1'b0, divisor[k-1]};
    assign ge      = shifted >= {1'b0, divisor[k-1]};

    always_ff @(posedge clk) begin
      if (rst) begin
        ctl_s[k].valid <= 1'b0;
      end else begin
        ctl_s[k] <= ctl_s[k-1];
      end
      rem[k]     <= ge ? diff[VALUE_BITS-1:0] : shifted[VALUE_BITS-1:0];
      divisor[k] <= divisor[k-1];
      quo[k]     <= {quo[k-1][ccm_pkg::A_FRAC-2:0], ge};
      one_s[k]   <= one_s[k-1];
      zero_s[k]  <= zero_s[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_out.valid <= 1'b0;
    end else begin
      ctl_out <= ctl_s[NSTAGE];
    end
    if (one_s[NSTAGE]) begin
      alpha <= ccm_pkg::ALPHA_ONE;
    end else if (zero_s[NSTAGE]) begin
      alpha <= '0;
    end else begin
      alpha <= {1'b0, quo[NSTAGE]};
    end
  end

  `CCM_ASSERT_IMPLIES(a_flags_exclusive, ctl_s[0].valid, !(one_s[0] && zero_s[0]))
  `CCM_ASSERT_IMPLIES(a_rem_below_divisor,
    ctl_s[NSTAGE].valid && !one_s[NSTAGE] && !zero_s[NSTAGE],
    rem[NSTAGE] < divisor[NSTAGE])
  `CCM_ASSERT_IMPLIES(a_alpha_range, ctl_out.valid, alpha <= ccm_pkg::ALPHA_ONE)

endmodule
